/* src/vpc_pkg.sv */
`timescale 1ns / 1ps

package vpc_pkg;

  // function codes of an input word
  localparam logic [1:0] FN_TICK    = 2'd0;
  localparam logic [1:0] FN_COLLIDE = 2'd1;
  localparam logic [1:0] FN_PLACE   = 2'd2;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RG_FRICTION = 2'd0;
  localparam logic [1:0] RG_BOUNCE   = 2'd1;
  localparam logic [1:0] RG_DRAG     = 2'd2;
  localparam logic [1:0] RG_GRAVITY  = 2'd3;

  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [6:0]  FRICTION_RST = 7'd5;
  localparam logic [6:0]  BOUNCE_RST   = 7'd30;
  localparam logic [6:0]  DRAG_RST     = 7'd99;
  localparam logic [16:0] GRAVITY_RST  = 17'd51;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
  } out_word_t;

  typedef struct packed {
    logic [6:0]         friction_pct;
    logic [6:0]         bounce_pct;
    logic [6:0]         drag_pct;
    logic signed [16:0] gravity_q8;
  } cfg_regs_t;

endpackage

/* src/vpc_div100.sv */
`timescale 1ns / 1ps

module vpc_div100 import vpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] dividend,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  // floor(v / 100) == (v * 5243) >> 19 for every v below 25600
  localparam logic [12:0] RECIP     = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;
  localparam logic [2:0]  LAST_STEP = 3'd4;

  logic        busy_r;
  logic        done_r;
  logic [2:0]  cnt_r;
  logic        neg_r;
  logic [39:0] mag_r;
  logic [6:0]  rem_r;
  logic [31:0] quo_r;
  logic [31:0] res_r;

  logic [14:0] step_v;
  logic [27:0] step_prod;
  logic [7:0]  step_q;
  logic [14:0] step_rem;
  logic [31:0] quo_nxt;
  logic [39:0] dividend_neg;

  assign step_v       = {rem_r, mag_r[39:32]};
  assign step_prod    = 28'(step_v) * 28'(RECIP);
  assign step_q       = step_prod[RECIP_SH +: 8];
  assign step_rem     = step_v - 15'(step_q) * 15'd100;
  assign quo_nxt      = {quo_r[23:0], step_q};
  assign dividend_neg = (~dividend) + 40'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one byte of the magnitude per cycle, remainder carried below 100
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[39];
      mag_r <= dividend[39] ? dividend_neg : dividend;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[31:0], 8'd0};
      rem_r <= step_rem[6:0];
      quo_r <= quo_nxt;
      if (cnt_r == LAST_STEP) begin
        res_r <= neg_r ? (~quo_nxt) + 32'd1 : quo_nxt;
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> rem_r < 7'd100)
    else $error("divider remainder out of range");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && cnt_r == LAST_STEP |=> done_r && !busy_r)
    else $error("divider did not finish after last step");

endmodule

/* src/vpc_core.sv */
`timescale 1ns / 1ps

module vpc_core import vpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_word_t  item,
  input  cfg_regs_t cfg,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DLOAD  = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_APPLY  = 3'd5;
  localparam logic [2:0] ST_COMMIT = 3'd6;

  // jobs run in code order; a collision skips the response jobs when d >= 0
  localparam logic [3:0] JB_TX_POS = 4'd0;
  localparam logic [3:0] JB_TX_OLD = 4'd1;
  localparam logic [3:0] JB_TY_POS = 4'd2;
  localparam logic [3:0] JB_TY_OLD = 4'd3;
  localparam logic [3:0] JB_DOT_X  = 4'd4;
  localparam logic [3:0] JB_DOT_Y  = 4'd5;
  localparam logic [3:0] JB_NRM_X  = 4'd6;
  localparam logic [3:0] JB_NRM_Y  = 4'd7;
  localparam logic [3:0] JB_FRC_X  = 4'd8;
  localparam logic [3:0] JB_BNC_X  = 4'd9;
  localparam logic [3:0] JB_FRC_Y  = 4'd10;
  localparam logic [3:0] JB_BNC_Y  = 4'd11;

  logic [2:0] state_r, state_nxt;
  logic [3:0] job_r, job_nxt;

  in_word_t item_r;
  logic signed [31:0] cur_x_r, cur_y_r, prv_x_r, prv_y_r;
  logic signed [31:0] vx_r, vy_r, d_r, nx_r, ny_r, tx_r, ty_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic signed [48:0] dot_r, prod_r;

  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] prod_nxt;
  logic signed [48:0] dot_sum;
  logic signed [31:0] prod_q14;
  logic signed [16:0] drag_b, fric_b, bnc_b, nrm_x_b, nrm_y_b;
  logic [7:0]         bnc_pct;
  logic signed [31:0] grav32;
  logic               need_div;

  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_q;

  assign bnc_pct = {1'b0, cfg.bounce_pct} + 8'd100;
  assign drag_b  = {10'd0, cfg.drag_pct};
  assign fric_b  = {10'd0, cfg.friction_pct};
  assign bnc_b   = {9'd0, bnc_pct};
  assign nrm_x_b = {item_r.normal_x[15], item_r.normal_x};
  assign nrm_y_b = {item_r.normal_y[15], item_r.normal_y};
  assign grav32  = {{15{cfg.gravity_q8[16]}}, cfg.gravity_q8};

  // shared multiplier operand select
  always_comb begin
    mul_a = cur_x_r;
    mul_b = drag_b;
    case (job_r)
      JB_TX_POS: mul_a = cur_x_r;
      JB_TX_OLD: mul_a = prv_x_r;
      JB_TY_POS: mul_a = cur_y_r;
      JB_TY_OLD: mul_a = prv_y_r;
      JB_DOT_X: begin
        mul_a = vx_r;
        mul_b = nrm_x_b;
      end
      JB_DOT_Y: begin
        mul_a = vy_r;
        mul_b = nrm_y_b;
      end
      JB_NRM_X: begin
        mul_a = d_r;
        mul_b = nrm_x_b;
      end
      JB_NRM_Y: begin
        mul_a = d_r;
        mul_b = nrm_y_b;
      end
      JB_FRC_X: begin
        mul_a = tx_r;
        mul_b = fric_b;
      end
      JB_BNC_X: begin
        mul_a = nx_r;
        mul_b = bnc_b;
      end
      JB_FRC_Y: begin
        mul_a = ty_r;
        mul_b = fric_b;
      end
      JB_BNC_Y: begin
        mul_a = ny_r;
        mul_b = bnc_b;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (job_r) inside
      JB_DOT_X, JB_DOT_Y, JB_NRM_X, JB_NRM_Y: need_div = 1'b0;
      default:                                need_div = 1'b1;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign dot_sum  = dot_r + prod_r;
  assign prod_q14 = prod_r[45:14];

  assign div_start = (state_r == ST_DLOAD);

  vpc_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[39:0]),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        unique case (item_r.func)
          FN_TICK: begin
            job_nxt   = JB_TX_POS;
            state_nxt = ST_MUL;
          end
          FN_COLLIDE: begin
            job_nxt   = JB_DOT_X;
            state_nxt = ST_MUL;
          end
          default: state_nxt = ST_COMMIT;
        endcase
      end
      ST_MUL:   state_nxt = need_div ? ST_DLOAD : ST_APPLY;
      ST_DLOAD: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        case (job_r) inside
          JB_TY_OLD, JB_BNC_Y: state_nxt = ST_COMMIT;
          JB_NRM_Y: begin
            // no response when the velocity leaves the surface
            if (d_r[31]) begin
              job_nxt   = JB_FRC_X;
              state_nxt = ST_MUL;
            end else begin
              state_nxt = ST_COMMIT;
            end
          end
          default: begin
            job_nxt   = job_r + 4'd1;
            state_nxt = ST_MUL;
          end
        endcase
      end
      ST_COMMIT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign item_ready = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_COMMIT);

  always_comb begin
    res.cur_x  = cur_x_r;
    res.cur_y  = cur_y_r;
    res.prev_x = prv_x_r;
    res.prev_y = prv_y_r;
    unique case (item_r.func)
      FN_TICK: begin
        res.cur_x  = acc_x_r;
        res.cur_y  = acc_y_r;
        res.prev_x = cur_x_r;
        res.prev_y = cur_y_r;
      end
      FN_COLLIDE: begin
        res.cur_x  = cur_x_r + item_r.push_x;
        res.cur_y  = cur_y_r + item_r.push_y;
        res.prev_x = prv_x_r + item_r.push_x + acc_x_r;
        res.prev_y = prv_y_r + item_r.push_y + acc_y_r;
      end
      FN_PLACE: begin
        res.cur_x  = item_r.place_x;
        res.cur_y  = item_r.place_y;
        res.prev_x = item_r.place_x;
        res.prev_y = item_r.place_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= JB_TX_POS;
      cur_x_r <= '0;
      cur_y_r <= '0;
      prv_x_r <= '0;
      prv_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      if (res_valid && res_ready) begin
        cur_x_r <= res.cur_x;
        cur_y_r <= res.cur_y;
        prv_x_r <= res.prev_x;
        prv_y_r <= res.prev_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_r <= item;
    if (state_r == ST_SETUP) begin
      vx_r <= cur_x_r - prv_x_r;
      vy_r <= cur_y_r - prv_y_r;
      // a tick builds the new position on top of the current one
      acc_x_r <= (item_r.func == FN_TICK) ? cur_x_r : '0;
      acc_y_r <= (item_r.func == FN_TICK) ? cur_y_r : '0;
    end
    if (state_r == ST_MUL) prod_r <= prod_nxt;
    if (state_r == ST_APPLY) begin
      case (job_r) inside
        JB_TX_POS, JB_FRC_X, JB_BNC_X: acc_x_r <= acc_x_r + div_q;
        JB_TX_OLD:                     acc_x_r <= acc_x_r - div_q;
        JB_TY_POS, JB_FRC_Y, JB_BNC_Y: acc_y_r <= acc_y_r + div_q;
        JB_TY_OLD:                     acc_y_r <= acc_y_r - div_q + grav32;
        JB_DOT_X:                      dot_r   <= prod_r;
        JB_DOT_Y:                      d_r     <= dot_sum[45:14];
        JB_NRM_X: begin
          nx_r <= prod_q14;
          tx_r <= vx_r - prod_q14;
        end
        JB_NRM_Y: begin
          ny_r <= prod_q14;
          ty_r <= vy_r - prod_q14;
        end
        default: ;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DWAIT)
    else $error("quotient arrived outside the wait state");

  a_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == ST_DWAIT)
    else $error("divider busy outside the wait state");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && res_ready) |=> $stable(cur_x_r) && $stable(cur_y_r)
      && $stable(prv_x_r) && $stable(prv_y_r))
    else $error("particle state changed without a result");

  a_skip_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY && job_r == JB_NRM_Y && !d_r[31] |=> state_r == ST_COMMIT)
    else $error("response applied for a separating velocity");

endmodule

/* src/verlet_particle_collision_step_top.sv */
`timescale 1ns / 1ps

// One Verlet particle with collision response, positions in signed Q24.8.
// Input channel (in_valid/in_ready/in_data): one word per step; func selects
// a tick, a collision report or a place. Every word gives one result word on
// the output channel (out_valid/out_ready/out_data) with the positions after
// the step. Settings sit in an APB register file: friction, bounce and drag
// in percent, gravity in signed Q9.8, at byte addresses 0, 4, 8 and 12.
// A place or an unused code needs no product; a tick scales four products,
// and a collision forms four unscaled products and, when the velocity
// points into the surface, scales four more. Each product goes through one
// shared 32x17 multiplier, and each percent scaling through a byte-serial
// divide-by-100 unit (five byte steps). One word is in work at a time;
// in_ready rises again the cycle after its result is handed to the output
// register. While the receiver stalls a finished result waits in the output
// register and the next word is still taken and worked on; its result holds
// inside until the register drains. Reset clears the positions to zero and
// loads the register defaults (5, 30, 99, 51).
module verlet_particle_collision_step_top import vpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_regs_t cfg_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  logic      res_valid;
  logic      res_ready;
  out_word_t res;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.friction_pct <= FRICTION_RST;
      cfg_r.bounce_pct   <= BOUNCE_RST;
      cfg_r.drag_pct     <= DRAG_RST;
      cfg_r.gravity_q8   <= GRAVITY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RG_FRICTION: cfg_r.friction_pct <= pwdata[6:0];
        RG_BOUNCE:   cfg_r.bounce_pct   <= pwdata[6:0];
        RG_DRAG:     cfg_r.drag_pct     <= pwdata[6:0];
        RG_GRAVITY:  cfg_r.gravity_q8   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RG_FRICTION: prdata = {25'd0, cfg_r.friction_pct};
      RG_BOUNCE:   prdata = {25'd0, cfg_r.bounce_pct};
      RG_DRAG:     prdata = {25'd0, cfg_r.drag_pct};
      RG_GRAVITY:  prdata = {15'd0, cfg_r.gravity_q8};
      default:     prdata = '0;
    endcase
  end

  vpc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output word register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/vpc_checker.sv */
`timescale 1ns / 1ps

module vpc_checker import vpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    outstanding
);

  localparam longint PCT = 100;

  // particle state and register copies
  int                 pos_x, pos_y, old_x, old_y;
  logic [6:0]         friction, bounce, drag;
  logic signed [16:0] gravity;

  out_word_t pending_pos[$];
  int        mismatches = 0;

  function automatic longint w32(input longint v);
    int t;
    t = int'(v);
    return longint'(t);
  endfunction

  // apply one word to the particle and return the positions after it
  function automatic out_word_t advance_particle(input in_word_t w);
    longint    cx, cy, ox, oy, dr, vx, vy, d, nx, ny, tx, ty, fx, fy, bx, by, fr, bo;
    longint    nrx, nry, shx, shy, kx, ky;
    int        push_x_i, push_y_i;
    shortint   norm_x_s, norm_y_s;
    out_word_t r;
    cx = longint'(pos_x);
    cy = longint'(pos_y);
    ox = longint'(old_x);
    oy = longint'(old_y);
    case (w.func)
      FN_TICK: begin
        dr = longint'(drag);
        kx = w32(cx + cx * dr / PCT - ox * dr / PCT);
        ky = w32(cy + cy * dr / PCT - oy * dr / PCT);
        ky = w32(ky + longint'(gravity));
        old_x = pos_x;
        old_y = pos_y;
        pos_x = int'(kx);
        pos_y = int'(ky);
      end
      FN_COLLIDE: begin
        push_x_i = w.push_x;
        push_y_i = w.push_y;
        norm_x_s = w.normal_x;
        norm_y_s = w.normal_y;
        shx = longint'(push_x_i);
        shy = longint'(push_y_i);
        nrx = longint'(norm_x_s);
        nry = longint'(norm_y_s);
        vx = w32(cx - ox);
        vy = w32(cy - oy);
        d  = w32((vx * nrx + vy * nry) >>> 14);
        nx = w32((d * nrx) >>> 14);
        ny = w32((d * nry) >>> 14);
        tx = w32(vx - nx);
        ty = w32(vy - ny);
        fx = 0;
        fy = 0;
        bx = 0;
        by = 0;
        // response only when moving into the surface
        if (d < 0) begin
          fr = longint'(friction);
          bo = longint'(bounce) + PCT;
          fx = w32(tx * fr / PCT);
          fy = w32(ty * fr / PCT);
          bx = w32(nx * bo / PCT);
          by = w32(ny * bo / PCT);
        end
        pos_x = int'(cx + shx);
        pos_y = int'(cy + shy);
        old_x = int'(ox + shx + bx + fx);
        old_y = int'(oy + shy + by + fy);
      end
      FN_PLACE: begin
        pos_x = w.place_x;
        pos_y = w.place_y;
        old_x = w.place_x;
        old_y = w.place_y;
      end
      default: ;
    endcase
    r.cur_x  = pos_x;
    r.cur_y  = pos_y;
    r.prev_x = old_x;
    r.prev_y = old_y;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      pos_x    = 0;
      pos_y    = 0;
      old_x    = 0;
      old_y    = 0;
      friction = FRICTION_RST;
      bounce   = BOUNCE_RST;
      drag     = DRAG_RST;
      gravity  = GRAVITY_RST;
      pending_pos.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RG_FRICTION: friction = pwdata[6:0];
          RG_BOUNCE:   bounce   = pwdata[6:0];
          RG_DRAG:     drag     = pwdata[6:0];
          RG_GRAVITY:  gravity  = pwdata[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_pos.push_back(advance_particle(in_data));
      if (out_valid && out_ready) begin
        if (pending_pos.size() == 0) begin
          $error("result word with no input word outstanding");
          mismatches++;
        end else begin
          want = pending_pos.pop_front();
          check_field("cur_x", want.cur_x, out_data.cur_x);
          check_field("cur_y", want.cur_y, out_data.cur_y);
          check_field("prev_x", want.prev_x, out_data.prev_x);
          check_field("prev_y", want.prev_y, out_data.prev_y);
        end
      end
    end
    outstanding <= pending_pos.size();
    fail_count  <= mismatches;
  end

endmodule

/* sim/verlet_particle_collision_step_top_tb.sv */
`timescale 1ns / 1ps

module verlet_particle_collision_step_top_tb;
  import vpc_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  in_word_t              in_data  = '0;
  logic                  out_ready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_word_t             out_data;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int in_idle_pct  = 26;
  int out_idle_pct = 65;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL verlet_particle_collision_step_top");
    $finish;
  end

  verlet_particle_collision_step_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  vpc_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic in_word_t mk(input logic [1:0] f, input int sx, input int sy,
                                  input shortint nx, input shortint ny,
                                  input int lx, input int ly);
    in_word_t w;
    w.func     = f;
    w.push_x   = sx;
    w.push_y   = sy;
    w.normal_x = nx;
    w.normal_y = ny;
    w.place_x  = lx;
    w.place_y  = ly;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    w.push_x   = $urandom;
    w.push_y   = $urandom;
    w.normal_x = 16'($urandom);
    w.normal_y = 16'($urandom);
    w.place_x  = $urandom;
    w.place_y  = $urandom;
    pick = $urandom_range(99);
    if (pick < 38)      w.func = FN_TICK;
    else if (pick < 75) w.func = FN_COLLIDE;
    else if (pick < 95) w.func = FN_PLACE;
    else                w.func = FN_UNUSED;
    // mostly modest values so motion stays readable, sometimes the full range
    if ($urandom_range(4) != 0) begin
      w.push_x = int'($urandom_range(8192)) - 4096;
      w.push_y = int'($urandom_range(8192)) - 4096;
    end
    if ($urandom_range(5) != 0) begin
      w.place_x = int'($urandom_range(2097152)) - 1048576;
      w.place_y = int'($urandom_range(2097152)) - 1048576;
    end
    pick = $urandom_range(9);
    if (pick < 6) begin
      w.normal_x = 16'(int'($urandom_range(32768)) - 16384);
      w.normal_y = 16'(int'($urandom_range(32768)) - 16384);
    end else if (pick < 8) begin
      w.normal_x = '0;
      w.normal_y = '0;
      if ($urandom_range(1))
        w.normal_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      else
        w.normal_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    end else if (pick == 8) begin
      w.normal_x = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
      w.normal_y = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_regs(input int fric, input int bnc, input int drg, input int grav);
    reg_write(RG_FRICTION, 32'(fric));
    reg_write(RG_BOUNCE, 32'(bnc));
    reg_write(RG_DRAG, 32'(drg));
    reg_write(RG_GRAVITY, 32'(grav));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset settings
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_PLACE, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_PLACE, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_PLACE, 0, 0, 0, 0, 5000, 10000));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    // moving down into a floor, then away from a ceiling
    send_word(mk(FN_COLLIDE, 0, -300, 0, -16384, 0, 0));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_COLLIDE, 0, 0, 0, 16384, 0, 0));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_COLLIDE, 64, -64, 11585, -11585, 0, 0));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_COLLIDE, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_COLLIDE, 32'h7FFF_FFFF, 32'h8000_0000, -16384, 16384, 0, 0));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    // normal far from unit length
    send_word(mk(FN_COLLIDE, 0, 0, 16'sh7FFF, 16'sh8000, 0, 0));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_UNUSED, -1, -1, -1, -1, -1, -1));
    send_word(mk(FN_PLACE, 0, 0, 0, 0, -1, -1));
    send_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0));
    send_word(mk(FN_COLLIDE, -100, 0, -16384, 0, 0, 0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin in_idle_pct = 26; out_idle_pct = 65; end
        1: begin in_idle_pct = 65; out_idle_pct = 26; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      if (ph > 0) begin
        in_valid <= 1'b0;
        wait_drained();
        case (ph)
          1: set_regs(0, 0, 0, -65536);
          2: set_regs(100, 100, 100, 65535);
          3: set_regs(127, 127, 127, 0);
          default: set_regs($urandom_range(127), $urandom_range(127), $urandom_range(127),
                            int'($urandom_range(131071)) - 65536);
        endcase
      end
      for (int k = 0; k < 190; k++) begin
        if ($urandom_range(79) == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_word(random_word());
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS verlet_particle_collision_step_top");
    else
      $display("FAIL verlet_particle_collision_step_top");
    $finish;
  end

endmodule

/* filelist.f */
src/vpc_pkg.sv
src/vpc_div100.sv
src/vpc_core.sv
src/verlet_particle_collision_step_top.sv
sim/vpc_checker.sv
sim/verlet_particle_collision_step_top_tb.sv
